// ===== rtl/index_doubly_linked_list_unit_assert.svh =====
// Assertion macros for the index doubly linked list unit
`ifndef INDEX_DOUBLY_LINKED_LIST_UNIT_ASSERT_SVH
`define INDEX_DOUBLY_LINKED_LIST_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a condition on every clock edge outside reset
`define IDLL_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) cond) \
		else $error("idll assertion failed");
// Check that a condition holds in the cycle after a trigger
`define IDLL_ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) trig |=> cond) \
		else $error("idll sequencing assertion failed");
`else
`define IDLL_ASSERT(lbl, cond)
`define IDLL_ASSERT_NEXT(lbl, trig, cond)
`endif

`endif

// ===== rtl/idll_pkg.sv =====
// Shared types and constants of the index doubly linked list unit
package idll_pkg;

	localparam int IDX_W  = 10;
	localparam int OP_W   = 3;
	localparam int LID_W  = 2;
	localparam int IN_W   = 24;
	localparam int OUT_W  = 32;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd1;
	localparam logic [OP_W-1:0] OP_DEL_HEAD   = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_TAIL   = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_ENTRY  = 3'd4;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIRST,
		ST_SECOND
	} state_t;

	// One write to a link memory
	typedef struct packed {
		logic we;
		idx_t addr;
		idx_t data;
	} link_wr_t;

endpackage

// ===== rtl/index_doubly_linked_list_unit.sv =====
// Top level of the index doubly linked list unit
// Each operation passes through the states IDLE, FIRST and SECOND: the transaction is
// accepted in IDLE while both link memories are read at the one entry it concerns, FIRST
// writes the first pair of links, SECOND writes the second pair and loads the result
// register; the split follows from the single write port of each link memory. The result
// register lets the next transaction be accepted while a result waits; SECOND is held
// while an earlier result is not yet taken. The link memories are not cleared after reset:
// an entry must be written before it is read. List heads and tails reset to zero.
`include "index_doubly_linked_list_unit_assert.svh"

module index_doubly_linked_list_unit #(
	parameter int ENTRIES = 1024,
	parameter int LISTS   = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// operation [2:0], entry_index [12:3], anchor_index [22:13], zero [23]
	input  logic [idll_pkg::IN_W-1:0]      s_tdata,
	// list_id [1:0]
	input  logic [idll_pkg::LID_W-1:0]     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// result_index [9:0], new_head [19:10], new_tail [29:20], zero [31:30]
	output logic [idll_pkg::OUT_W-1:0]     m_tdata
);

	localparam int AW = $clog2(ENTRIES);
	localparam int LW = (LISTS > 1) ? $clog2(LISTS) : 1;

	// Input fields
	logic [idll_pkg::OP_W-1:0] in_op;
	idll_pkg::idx_t            in_ent;
	idll_pkg::idx_t            in_anc;
	logic [LW-1:0]             in_lid;
	logic                      in_lid_ok;
	logic                      in_ent_ok;
	logic                      in_anc_ok;
	logic                      in_act;
	idll_pkg::idx_t            in_head;
	idll_pkg::idx_t            in_tail;
	idll_pkg::idx_t            rd_key;
	logic                      accept;

	// Control state
	idll_pkg::state_t state_q;
	idll_pkg::state_t state_d;
	idll_pkg::idx_t   head_q [LISTS];
	idll_pkg::idx_t   tail_q [LISTS];
	logic             m_tvalid_q;

	// Latched request
	logic [idll_pkg::OP_W-1:0] op_q;
	logic [LW-1:0]             lid_q;
	logic                      lid_ok_q;
	logic                      act_q;
	idll_pkg::idx_t            ent_q;
	idll_pkg::idx_t            anc_q;

	// Link memories and their read data
	idll_pkg::idx_t next_mem [ENTRIES];
	idll_pkg::idx_t prev_mem [ENTRIES];
	idll_pkg::idx_t next_rd_q;
	idll_pkg::idx_t prev_rd_q;

	// FIRST state: links, list update and second write pair
	idll_pkg::idx_t     cur_head;
	idll_pkg::idx_t     cur_tail;
	idll_pkg::idx_t     cur_ent;
	idll_pkg::link_wr_t x_next;
	idll_pkg::link_wr_t x_prev;
	idll_pkg::link_wr_t y_next;
	idll_pkg::link_wr_t y_prev;
	logic               upd_head;
	logic               upd_tail;
	idll_pkg::idx_t     new_head;
	idll_pkg::idx_t     new_tail;

	// SECOND state
	idll_pkg::link_wr_t y_next_s2;
	idll_pkg::link_wr_t y_prev_s2;
	idll_pkg::idx_t     res_s2;
	idll_pkg::link_wr_t next_wr;
	idll_pkg::link_wr_t prev_wr;
	logic               out_load;
	idll_pkg::idx_t     out_head;
	idll_pkg::idx_t     out_tail;
	logic [idll_pkg::OUT_W-1:0] out_q;

	// Unpack the input transaction and qualify it
	assign in_op     = s_tdata[2:0];
	assign in_ent    = s_tdata[12:3];
	assign in_anc    = s_tdata[22:13];
	assign in_lid    = LW'(s_tuser);
	assign in_lid_ok = 32'(s_tuser) < 32'(LISTS);
	assign in_ent_ok = (in_ent != '0) && (32'(in_ent) < 32'(ENTRIES));
	assign in_anc_ok = 32'(in_anc) < 32'(ENTRIES);
	assign in_head   = in_lid_ok ? head_q[in_lid] : '0;
	assign in_tail   = in_lid_ok ? tail_q[in_lid] : '0;
	assign accept    = s_tvalid && s_tready;

	always_comb begin
		in_act = 1'b0;
		rd_key = in_anc;
		unique case (in_op)
			idll_pkg::OP_INS_BEFORE,
			idll_pkg::OP_INS_AFTER: begin
				in_act = in_lid_ok && in_ent_ok && in_anc_ok;
			end
			idll_pkg::OP_DEL_HEAD: begin
				in_act = in_lid_ok && (in_head != '0);
				rd_key = in_head;
			end
			idll_pkg::OP_DEL_TAIL: begin
				in_act = in_lid_ok && (in_tail != '0);
				rd_key = in_tail;
			end
			idll_pkg::OP_DEL_ENTRY: begin
				in_act = in_lid_ok && in_ent_ok;
				rd_key = in_ent;
			end
			default: begin
				in_act = 1'b0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			idll_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = idll_pkg::ST_FIRST;
			end
			idll_pkg::ST_FIRST: begin
				state_d = idll_pkg::ST_SECOND;
			end
			idll_pkg::ST_SECOND: begin
				if (!m_tvalid_q || m_tready) state_d = idll_pkg::ST_IDLE;
			end
			default: begin
				state_d = idll_pkg::ST_IDLE;
			end
		endcase
	end

	// State outputs: handshake, memory write ports and result load
	always_comb begin
		s_tready = 1'b0;
		next_wr  = '0;
		prev_wr  = '0;
		out_load = 1'b0;
		unique case (state_q)
			idll_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			idll_pkg::ST_FIRST: begin
				next_wr = x_next;
				prev_wr = x_prev;
			end
			idll_pkg::ST_SECOND: begin
				// repeated writes while held are identical and harmless
				next_wr  = y_next_s2;
				prev_wr  = y_prev_s2;
				out_load = !m_tvalid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// Link rewiring for the latched operation
	assign cur_head = head_q[lid_q];
	assign cur_tail = tail_q[lid_q];

	always_comb begin
		x_next   = '0;
		x_prev   = '0;
		y_next   = '0;
		y_prev   = '0;
		upd_head = 1'b0;
		upd_tail = 1'b0;
		new_head = cur_head;
		new_tail = cur_tail;
		cur_ent  = ent_q;
		unique case (op_q)
			idll_pkg::OP_INS_BEFORE: begin
				if (anc_q == '0) begin
					// append after the current tail
					x_next   = '{we: (cur_tail != '0), addr: cur_tail, data: ent_q};
					x_prev   = '{we: 1'b1, addr: ent_q, data: cur_tail};
					y_next   = '{we: 1'b1, addr: ent_q, data: '0};
					upd_head = (cur_tail == '0);
					new_head = ent_q;
					upd_tail = 1'b1;
					new_tail = ent_q;
				end else begin
					x_prev   = '{we: 1'b1, addr: anc_q, data: ent_q};
					x_next   = '{we: 1'b1, addr: ent_q, data: anc_q};
					y_prev   = '{we: 1'b1, addr: ent_q, data: prev_rd_q};
					y_next   = '{we: (prev_rd_q != '0), addr: prev_rd_q, data: ent_q};
					upd_head = (prev_rd_q == '0);
					new_head = ent_q;
				end
			end
			idll_pkg::OP_INS_AFTER: begin
				if (anc_q == '0) begin
					// prepend before the current head
					x_prev   = '{we: (cur_head != '0), addr: cur_head, data: ent_q};
					x_next   = '{we: 1'b1, addr: ent_q, data: cur_head};
					y_prev   = '{we: 1'b1, addr: ent_q, data: '0};
					upd_tail = (cur_head == '0);
					new_tail = ent_q;
					upd_head = 1'b1;
					new_head = ent_q;
				end else begin
					x_next   = '{we: 1'b1, addr: anc_q, data: ent_q};
					x_prev   = '{we: 1'b1, addr: ent_q, data: anc_q};
					y_next   = '{we: 1'b1, addr: ent_q, data: next_rd_q};
					y_prev   = '{we: (next_rd_q != '0), addr: next_rd_q, data: ent_q};
					upd_tail = (next_rd_q == '0);
					new_tail = ent_q;
				end
			end
			idll_pkg::OP_DEL_HEAD: begin
				cur_ent  = cur_head;
				x_prev   = '{we: (next_rd_q != '0), addr: next_rd_q, data: '0};
				x_next   = '{we: 1'b1, addr: cur_head, data: '0};
				y_prev   = '{we: 1'b1, addr: cur_head, data: '0};
				upd_tail = (next_rd_q == '0);
				new_tail = '0;
				upd_head = 1'b1;
				new_head = next_rd_q;
			end
			idll_pkg::OP_DEL_TAIL: begin
				cur_ent  = cur_tail;
				x_next   = '{we: (prev_rd_q != '0), addr: prev_rd_q, data: '0};
				x_prev   = '{we: 1'b1, addr: cur_tail, data: '0};
				y_next   = '{we: 1'b1, addr: cur_tail, data: '0};
				upd_head = (prev_rd_q == '0);
				new_head = '0;
				upd_tail = 1'b1;
				new_tail = prev_rd_q;
			end
			idll_pkg::OP_DEL_ENTRY: begin
				x_prev   = '{we: (next_rd_q != '0), addr: next_rd_q, data: prev_rd_q};
				x_next   = '{we: (prev_rd_q != '0), addr: prev_rd_q, data: next_rd_q};
				y_next   = '{we: 1'b1, addr: ent_q, data: '0};
				y_prev   = '{we: 1'b1, addr: ent_q, data: '0};
				upd_tail = (next_rd_q == '0);
				new_tail = prev_rd_q;
				upd_head = (prev_rd_q == '0);
				new_head = next_rd_q;
			end
			default: begin
				cur_ent = ent_q;
			end
		endcase
		// drop every update of an ignored request
		if (!act_q) begin
			x_next   = '0;
			x_prev   = '0;
			y_next   = '0;
			y_prev   = '0;
			upd_head = 1'b0;
			upd_tail = 1'b0;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= idll_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
			act_q      <= 1'b0;
			for (int i = 0; i < LISTS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (accept) act_q <= in_act;
			if (state_q == idll_pkg::ST_FIRST) begin
				if (upd_head) head_q[lid_q] <= new_head;
				if (upd_tail) tail_q[lid_q] <= new_tail;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Hold the accepted request
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= in_op;
			lid_q    <= in_lid;
			lid_ok_q <= in_lid_ok;
			ent_q    <= in_ent;
			anc_q    <= in_anc;
		end
	end

	// Advance the second write pair and the result index
	always_ff @(posedge clk) begin
		if (state_q == idll_pkg::ST_FIRST) begin
			y_next_s2 <= y_next;
			y_prev_s2 <= y_prev;
			res_s2    <= act_q ? cur_ent : '0;
		end
	end

	// Link memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (next_wr.we) next_mem[AW'(next_wr.addr)] <= next_wr.data;
		if (accept) next_rd_q <= next_mem[AW'(rd_key)];
	end

	always_ff @(posedge clk) begin
		if (prev_wr.we) prev_mem[AW'(prev_wr.addr)] <= prev_wr.data;
		if (accept) prev_rd_q <= prev_mem[AW'(rd_key)];
	end

	// Result register
	assign out_head = lid_ok_q ? head_q[lid_q] : '0;
	assign out_tail = lid_ok_q ? tail_q[lid_q] : '0;

	always_ff @(posedge clk) begin
		if (out_load) out_q <= {2'b00, out_tail, out_head, res_s2};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	`IDLL_ASSERT_NEXT(a_accept_starts, (s_tvalid && s_tready), (state_q == idll_pkg::ST_FIRST))
	`IDLL_ASSERT(a_idle_no_write, (state_q == idll_pkg::ST_IDLE) |-> (!next_wr.we && !prev_wr.we))
	`IDLL_ASSERT_NEXT(a_finish_loads, (state_q == idll_pkg::ST_SECOND && out_load), m_tvalid)

endmodule
